/* sv/wud_pkg.sv */
// shared constants and types of the wide unsigned divider
package wud_pkg;

    localparam int WIDTH  = 96;
    localparam int LOW_W  = 64;
    localparam int HIGH_W = 32;
    localparam int OP_W   = LOW_W + HIGH_W;
    localparam int EFF_W  = (WIDTH > OP_W) ? OP_W : WIDTH;
    localparam int CNT_W  = $clog2(EFF_W);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic ready;
        logic load;
        logic step;
        logic finish;
    } t_ctl;

endpackage

/* sv/wud_if.sv */
// request and response channel interfaces of the wide unsigned divider
interface wud_req_if import wud_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LOW_W-1:0]  dividend_low;
    logic [HIGH_W-1:0] dividend_high;
    logic [LOW_W-1:0]  divisor_low;
    logic [HIGH_W-1:0] divisor_high;

    modport source (output valid, dividend_low, dividend_high, divisor_low, divisor_high,
                    input ready);
    modport sink   (input valid, dividend_low, dividend_high, divisor_low, divisor_high,
                    output ready);
endinterface

interface wud_rsp_if import wud_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LOW_W-1:0]  quotient_low;
    logic [HIGH_W-1:0] quotient_high;
    logic [LOW_W-1:0]  rest_low;
    logic [HIGH_W-1:0] rest_high;
    logic              status;

    modport source (output valid, quotient_low, quotient_high, rest_low, rest_high, status,
                    input ready);
    modport sink   (input valid, quotient_low, quotient_high, rest_low, rest_high, status,
                    output ready);
endinterface

/* sv/wud_trial.sv */
// shared shift and trial subtract unit, one quotient bit per use
module wud_trial import wud_pkg::*; (
    input  logic [EFF_W-1:0] i_rem,
    input  logic             i_next_bit,
    input  logic [EFF_W-1:0] i_divisor,
    output logic [EFF_W-1:0] o_rem,
    output logic             o_ge
);

    logic [EFF_W:0]   shifted;
    logic [EFF_W+1:0] diff;

    assign shifted = {i_rem, i_next_bit};
    assign diff    = {1'b0, shifted} - {2'b00, i_divisor};
    // no borrow means the shifted remainder reached the divisor
    assign o_ge    = ~diff[EFF_W+1];
    assign o_rem   = o_ge ? diff[EFF_W-1:0] : shifted[EFF_W-1:0];

endmodule

/* sv/wud_ctrl.sv */
// sequencer: accept, one step per quotient bit (none for a zero divisor), hand over the result
module wud_ctrl import wud_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  logic i_div_zero,
    input  logic i_out_free,
    output t_ctl o_ctl
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_ctl        = '0;
        o_ctl.ready  = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_fire) begin
                    o_ctl.load = 1'b1;
                    n_cnt      = CNT_W'(EFF_W - 1);
                    // zero divisor skips the iterations
                    n_state    = i_div_zero ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                o_ctl.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* sv/wide_unsigned_divider_unit.sv */
// top level of the wide unsigned divider: operand registers, sequencer and result register
//
//  channel  | dir | beat
//  i_req    | in  | dividend_low, dividend_high, divisor_low, divisor_high
//  o_rsp    | out | quotient_low, quotient_high, rest_low, rest_high, status
//
// a beat is loaded, takes one step per quotient bit through the shared trial subtractor,
// and is handed over once the output register is free; a zero divisor skips the steps
// i_req.ready is high only while the sequencer is idle; a result waiting in the output
// register does not hold off the next request, only the hand-over of the one after
// synchronous active-low reset clears the sequencer and the output valid flag
module wide_unsigned_divider_unit import wud_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wud_req_if.sink    i_req,
    wud_rsp_if.source  o_rsp
);

    t_ctl             ctl;
    logic             fire;
    logic             out_free;
    logic             div_zero;
    logic [OP_W-1:0]  dividend_full;
    logic [OP_W-1:0]  divisor_full;
    logic [EFF_W-1:0] dividend_eff;
    logic [EFF_W-1:0] divisor_eff;

    logic [EFF_W-1:0] r_a;
    logic [EFF_W-1:0] r_b;
    logic [EFF_W-1:0] r_r;
    logic             r_zero;
    logic             r_out_valid;
    logic [OP_W-1:0]  r_quo;
    logic [OP_W-1:0]  r_rem;
    logic             r_status;

    logic [EFF_W-1:0] trial_rem;
    logic             trial_ge;

    assign dividend_full = {i_req.dividend_high, i_req.dividend_low};
    assign divisor_full  = {i_req.divisor_high, i_req.divisor_low};
    assign dividend_eff  = dividend_full[EFF_W-1:0];
    assign divisor_eff   = divisor_full[EFF_W-1:0];
    assign div_zero      = (divisor_eff == '0);

    assign fire        = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = ctl.ready;

    wud_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_div_zero (div_zero),
        .i_out_free (out_free),
        .o_ctl      (ctl)
    );

    wud_trial u_trial (
        .i_rem      (r_r),
        .i_next_bit (r_a[EFF_W-1]),
        .i_divisor  (r_b),
        .o_rem      (trial_rem),
        .o_ge       (trial_ge)
    );

    // dividend shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (ctl.load) begin
            r_a    <= div_zero ? '0 : dividend_eff;
            r_b    <= divisor_eff;
            r_r    <= '0;
            r_zero <= div_zero;
        end else if (ctl.step) begin
            r_a <= {r_a[EFF_W-2:0], trial_ge};
            r_r <= trial_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.finish) begin
            r_quo    <= OP_W'(r_a);
            r_rem    <= OP_W'(r_r);
            r_status <= r_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.quotient_low  = r_quo[LOW_W-1:0];
    assign o_rsp.quotient_high = r_quo[OP_W-1:LOW_W];
    assign o_rsp.rest_low      = r_rem[LOW_W-1:0];
    assign o_rsp.rest_high     = r_rem[OP_W-1:LOW_W];
    assign o_rsp.status        = r_status;

`ifndef NO_ASSERTIONS
    a_zero_status_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status) |->
            (o_rsp.quotient_low == '0 && o_rsp.quotient_high == '0 &&
             o_rsp.rest_low == '0 && o_rsp.rest_high == '0))
        else $error("zero divisor result carries nonzero fields");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> !i_req.ready)
        else $error("request accepted while a division is in flight");

    a_finish_needs_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.finish |-> out_free)
        else $error("result overwrote an untaken response");

    a_rem_below_divisor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.finish && !r_zero) |-> (r_r < r_b))
        else $error("remainder not below divisor at hand-over");
`endif

endmodule
